>>> sv/preemptive_priority_scheduler_defines.svh
// Assertion macros for the preemptive priority scheduler.
// Has no dependencies; included by preemptive_priority_scheduler, which carries the assertions.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/pps_pkg.sv
// Constants, types and helpers for the preemptive priority scheduler.
// Has no dependencies; imported by preemptive_priority_scheduler.
package pps_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int LEVELS      = 5;

   localparam int PRIO_W  = 3;
   localparam int ID_W    = 16;
   localparam int LVL_W   = $clog2(LEVELS);
   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W  = $clog2(MEM_DEPTH);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef enum logic {
      REQ_ADD       = 1'b0,
      REQ_TERMINATE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_PRIO = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef logic [LVL_W-1:0] lvl_type;
   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // Input payload, lowest field last in the list (packed from bit 0 up).
   typedef struct packed {
      logic [4:0]        pad;
      logic [ID_W-1:0]   task_id;
      logic [PRIO_W-1:0] task_priority;
   } req_data_type;

   typedef struct packed {
      logic [1:0]        pad;
      status_type        status;
      logic [PRIO_W-1:0] running_priority;
      logic [ID_W-1:0]   running_id;
      logic              running_valid;
   } rsp_data_type;

   function automatic ptr_type wrap_next(input ptr_type ptr);
      return (32'(ptr) + 1 >= QUEUE_DEPTH) ? '0 : PTR_W'(32'(ptr) + 1);
   endfunction

   function automatic addr_type entry_addr(input lvl_type lvl, input ptr_type ptr);
      return ADDR_W'(ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr));
   endfunction

endpackage

>>> sv/preemptive_priority_scheduler.sv
// Preemptive fixed-priority scheduler: ready queues in one memory, running slot,
// and a two-stage request pipeline. Depends on pps_pkg and the defines header.
//
// Usage:
//   req_* channel carries requests: req_tuser is the kind (add or terminate),
//   req_tdata the priority and task id of an added task. rsp_* returns one
//   result per request: the running task after that request and a status code.
//   A request is decided in the cycle it is accepted: queue pointers, counts and
//   the running slot update at that edge, and a dispatch reads the head entry
//   from the ready memory. The read data is registered beside the middle stage;
//   the result then moves from the middle stage into the output register that
//   drives rsp_*. One request per cycle is sustained while the receiver takes
//   responses; the single-port memory read of a dispatch and the queue write of
//   an add never collide. When the receiver stalls, the output register holds,
//   the middle stage holds behind it, and req_tready drops while the middle
//   stage is full until the output drains. Reset empties the running slot and
//   all queues; the ready memory is not cleared, only queued entries are read.
`include "preemptive_priority_scheduler_defines.svh"

module preemptive_priority_scheduler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // task_priority[2:0], task_id[18:3], zero pad [23:19]
   input  logic [pps_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_type: 0 add, 1 terminate
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // running_valid[0], running_id[16:1], running_priority[19:17], status[21:20],
   // zero pad [23:22]
   output logic [pps_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import pps_pkg::*;

   req_data_type      req_data;
   req_kind_type      req_kind;
   logic              req_accept;

   // ready queues
   logic [ID_W-1:0]   ready_mem [MEM_DEPTH];
   logic [ID_W-1:0]   mem_rdata_ff;
   ptr_type           head_ff  [LEVELS];
   ptr_type           head_in  [LEVELS];
   ptr_type           tail_ff  [LEVELS];
   ptr_type           tail_in  [LEVELS];
   cnt_type           count_ff [LEVELS];
   cnt_type           count_in [LEVELS];

   // running slot; the id lives in mem_rdata_ff right after a dispatch
   logic              slot_busy_ff, slot_busy_in;
   logic [ID_W-1:0]   slot_id_ff, slot_id_in;
   logic [PRIO_W-1:0] slot_prio_ff, slot_prio_in;
   logic              slot_from_mem_ff, slot_from_mem_in;
   logic [ID_W-1:0]   slot_id_eff;

   // decision logic
   logic              pop_any;
   lvl_type           pop_lvl;
   logic              mem_re, mem_we;
   addr_type          mem_raddr, mem_waddr;
   logic [ID_W-1:0]   mem_wdata;
   lvl_type           enq_lvl;
   logic              enq_req;
   logic              enq_full;
   status_type        status_new;

   // middle stage
   logic              s1_valid_ff;
   logic              s1_busy_ff;
   logic [ID_W-1:0]   s1_id_ff;
   logic [PRIO_W-1:0] s1_prio_ff;
   logic              s1_from_mem_ff;
   status_type        s1_status_ff;
   logic              s1_advance;

   // output stage
   logic              rsp_valid_ff;
   rsp_data_type      rsp_data_ff, rsp_data_in;
   logic              rsp_free;

   assign req_data   = req_data_type'(req_tdata);
   assign req_kind   = req_kind_type'(req_tuser);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || rsp_free;
   assign req_accept = req_tvalid && req_tready;

   assign slot_id_eff = slot_from_mem_ff ? mem_rdata_ff : slot_id_ff;

   // highest non-empty level
   always_comb begin
      pop_any = 1'b0;
      pop_lvl = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (count_ff[l] != '0) begin
            pop_any = 1'b1;
            pop_lvl = LVL_W'(l);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         head_in[l]  = head_ff[l];
         tail_in[l]  = tail_ff[l];
         count_in[l] = count_ff[l];
      end
      slot_busy_in     = slot_busy_ff;
      slot_id_in       = slot_id_ff;
      slot_prio_in     = slot_prio_ff;
      slot_from_mem_in = slot_from_mem_ff;
      status_new       = ST_OK;
      mem_re           = 1'b0;
      mem_raddr        = entry_addr(pop_lvl, head_ff[pop_lvl]);
      enq_req          = 1'b0;
      enq_lvl          = req_data.task_priority[LVL_W-1:0];
      mem_wdata        = req_data.task_id;

      if (req_kind == REQ_TERMINATE) begin
         if (pop_any) begin
            mem_re             = 1'b1;
            head_in[pop_lvl]   = wrap_next(head_ff[pop_lvl]);
            count_in[pop_lvl]  = CNT_W'(count_ff[pop_lvl] - 1'b1);
            slot_busy_in       = 1'b1;
            slot_prio_in       = PRIO_W'(pop_lvl);
            slot_from_mem_in   = 1'b1;
         end else begin
            slot_busy_in       = 1'b0;
            slot_prio_in       = '0;
            slot_id_in         = '0;
            slot_from_mem_in   = 1'b0;
         end
      end else if (32'(req_data.task_priority) >= LEVELS) begin
         status_new = ST_BAD_PRIO;
      end else if (!slot_busy_ff) begin
         slot_busy_in     = 1'b1;
         slot_id_in       = req_data.task_id;
         slot_prio_in     = req_data.task_priority;
         slot_from_mem_in = 1'b0;
      end else if (req_data.task_priority > slot_prio_ff) begin
         // preempt: running task goes to its level's tail, if that queue has room
         enq_req          = 1'b1;
         enq_lvl          = slot_prio_ff[LVL_W-1:0];
         mem_wdata        = slot_id_eff;
         slot_id_in       = req_data.task_id;
         slot_prio_in     = req_data.task_priority;
         slot_from_mem_in = 1'b0;
      end else begin
         enq_req = 1'b1;
      end

      enq_full  = count_ff[enq_lvl] == CNT_W'(QUEUE_DEPTH);
      mem_waddr = entry_addr(enq_lvl, tail_ff[enq_lvl]);
      mem_we    = 1'b0;
      if (enq_req) begin
         if (enq_full) begin
            status_new = ST_FULL;
         end else begin
            mem_we            = 1'b1;
            tail_in[enq_lvl]  = wrap_next(tail_ff[enq_lvl]);
            count_in[enq_lvl] = CNT_W'(count_ff[enq_lvl] + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && mem_we) begin
         ready_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept && mem_re) begin
         mem_rdata_ff <= ready_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
         slot_busy_ff     <= 1'b0;
         slot_id_ff       <= '0;
         slot_prio_ff     <= '0;
         slot_from_mem_ff <= 1'b0;
      end else if (req_accept) begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= head_in[l];
            tail_ff[l]  <= tail_in[l];
            count_ff[l] <= count_in[l];
         end
         slot_busy_ff     <= slot_busy_in;
         slot_id_ff       <= slot_id_in;
         slot_prio_ff     <= slot_prio_in;
         slot_from_mem_ff <= slot_from_mem_in;
      end
   end

   // middle stage: waits for the memory read of a dispatch
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_busy_ff     <= slot_busy_in;
         s1_id_ff       <= slot_id_in;
         s1_prio_ff     <= slot_prio_in;
         s1_from_mem_ff <= slot_from_mem_in;
         s1_status_ff   <= status_new;
      end
   end

   always_comb begin
      rsp_data_in                  = '0;
      rsp_data_in.running_valid    = s1_busy_ff;
      rsp_data_in.running_id       = s1_from_mem_ff ? mem_rdata_ff : s1_id_ff;
      rsp_data_in.running_priority = s1_prio_ff;
      rsp_data_in.status           = s1_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   `PPS_ASSERT_NOW(a_from_mem_busy, slot_from_mem_ff, slot_busy_ff, "slot id taken from memory while slot is empty")
   `PPS_ASSERT_NEXT(a_dispatch_marks, req_accept && mem_re, slot_from_mem_ff && slot_busy_ff, "dispatch did not mark the slot as read from memory")
   `PPS_ASSERT_NEXT(a_s1_holds, s1_valid_ff && !rsp_free, s1_valid_ff && $stable(s1_id_ff) && (!s1_from_mem_ff || $stable(mem_rdata_ff)), "middle stage changed while stalled")
   `PPS_ASSERT_NOW(a_empty_zero, rsp_valid_ff && !rsp_data_ff.running_valid, rsp_data_ff.running_id == '0 && rsp_data_ff.running_priority == '0, "empty slot reported with nonzero id or priority")
   `PPS_ASSERT_NOW(a_no_push_pop, req_accept, !(mem_we && mem_re), "queue write and dispatch read in one request")

endmodule
